>>> design/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg: shared types and tables for the base64 encoder
// Transaction structs, the queued group entry and the character table.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Number of bytes held in the current group
	localparam logic [1:0] CNT_ONE = 2'd1;
	localparam logic [1:0] CNT_TWO = 2'd2;

	// Last character position within a group
	localparam logic [1:0] POS_LAST = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} out_t;

	// One encoded group: four characters, index 0 goes out first
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic            last;
	} group_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Standard alphabet lookup for a six-bit value
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

>>> design/base64_encoder.sv
// The byte closing a group writes the encoded group into the queue, and the first
// character then loads into the output register, when the queue and output are idle.
// One byte per cycle goes into a two-group queue unless it is full, and one
// character per cycle comes out unless stalled; the single-character output
// register sets the group rate, so sustained input is limited by character output.
// Reset (arst_n low) empties the held group, the queue and the output.
// ----------------------------------------------------------------------------
// base64_encoder: streaming base64 encoder, standard alphabet with padding
// Front encodes groups, a short queue buffers them, back serializes chars.
// ----------------------------------------------------------------------------
module base64_encoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_stall,
	input  b64e_pkg::in_t   byte_data,
	output logic            char_valid,
	input  logic            char_stall,
	output b64e_pkg::out_t  char_data
);

	b64e_pkg::q_status_t q_status;
	b64e_pkg::group_t    push_data, head;
	logic                push, pop;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_status   (q_status),
		.push       (push),
		.push_data  (push_data)
	);

	b64e_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

endmodule

>>> design/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front: byte intake and group encoding
// Holds up to two bytes, forms a four-character group when one is complete or the stream ends.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  b64e_pkg::in_t        byte_data,
	input  b64e_pkg::q_status_t  q_status,
	output logic                 push,
	output b64e_pkg::group_t     push_data
);

	logic [15:0] held_q;
	logic [1:0]  count_q;
	logic        accept;
	logic [7:0]  b, b0, b1;

	assign byte_stall = q_status.full;
	assign accept     = byte_valid && !q_status.full;
	assign b          = byte_data.in_byte;
	assign b0         = held_q[15:8];
	assign b1         = held_q[7:0];

	// Encode the group that this byte would close
	always_comb begin
		push_data.last = byte_data.last_byte;
		push           = 1'b0;
		unique case (count_q)
			b64e_pkg::CNT_TWO: begin
				push              = accept;
				push_data.chars[0] = b64e_pkg::sextet_char(b0[7:2]);
				push_data.chars[1] = b64e_pkg::sextet_char({b0[1:0], b1[7:4]});
				push_data.chars[2] = b64e_pkg::sextet_char({b1[3:0], b[7:6]});
				push_data.chars[3] = b64e_pkg::sextet_char(b[5:0]);
			end
			b64e_pkg::CNT_ONE: begin
				push              = accept && byte_data.last_byte;
				push_data.chars[0] = b64e_pkg::sextet_char(b0[7:2]);
				push_data.chars[1] = b64e_pkg::sextet_char({b0[1:0], b[7:4]});
				push_data.chars[2] = b64e_pkg::sextet_char({b[3:0], 2'b00});
				push_data.chars[3] = b64e_pkg::PAD_CHAR;
			end
			default: begin
				// empty group (an unreachable count of three acts the same)
				push              = accept && byte_data.last_byte;
				push_data.chars[0] = b64e_pkg::sextet_char(b[7:2]);
				push_data.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
				push_data.chars[2] = b64e_pkg::PAD_CHAR;
				push_data.chars[3] = b64e_pkg::PAD_CHAR;
			end
		endcase
	end

	// Held bytes and group count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (push) begin
				held_q  <= '0;
				count_q <= '0;
			end else if (count_q == b64e_pkg::CNT_ONE) begin
				held_q  <= {b0, b};
				count_q <= b64e_pkg::CNT_TWO;
			end else begin
				held_q  <= {b, 8'h00};
				count_q <= b64e_pkg::CNT_ONE;
			end
		end
	end

endmodule

>>> design/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue: short group queue
// Decouples group encoding from character output.
// ----------------------------------------------------------------------------
module b64e_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  b64e_pkg::group_t     push_data,
	input  logic                 pop,
	output b64e_pkg::group_t     head,
	output b64e_pkg::q_status_t  status
);

	b64e_pkg::group_t                 mem_q [b64e_pkg::QDEPTH];
	logic [b64e_pkg::QAW-1:0]         wr_ptr_q, rd_ptr_q;
	logic [b64e_pkg::QCW-1:0]         count_q;
	logic                             do_push, do_pop;

	assign status.full  = (count_q == b64e_pkg::QCW'(b64e_pkg::QDEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == b64e_pkg::QAW'(b64e_pkg::QDEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == b64e_pkg::QAW'(b64e_pkg::QDEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back: character serializer
// Sends the four characters of the head group through an output register.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b64e_pkg::group_t     head,
	input  b64e_pkg::q_status_t  q_status,
	output logic                 pop,
	output logic                 char_valid,
	input  logic                 char_stall,
	output b64e_pkg::out_t       char_data
);

	logic           valid_q;
	b64e_pkg::out_t data_q;
	logic [1:0]     pos_q;
	logic           load;

	// Output register takes a character whenever the queue holds a group and it is empty or being drained
	assign load       = !q_status.empty && (!valid_q || !char_stall);
	assign pop        = load && (pos_q == b64e_pkg::POS_LAST);
	assign char_valid = valid_q;
	assign char_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				pos_q   <= pos_q + 1'b1;
			end else if (!char_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Character payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q.out_char <= head.chars[pos_q];
			data_q.out_last <= head.last && (pos_q == b64e_pkg::POS_LAST);
		end
	end

endmodule

>>> design/b64e_checker.sv
// ----------------------------------------------------------------------------
// b64e_checker: port-level checks for the base64 encoder
// Tracks character position within groups and checks output framing.
// ----------------------------------------------------------------------------
module b64e_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            char_valid,
	input logic            char_stall,
	input b64e_pkg::out_t  char_data
);

	logic [1:0] pos_q;
	logic       char_xfer;
	logic [7:0] c;

	assign char_xfer = char_valid && !char_stall;
	assign c         = char_data.out_char;

	// Position of the next character within its group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (char_xfer) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	// A stalled character holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(char_data))
		else $error("stalled character changed");

	// Only alphabet characters or pad appear
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
			|| (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F
			|| c == b64e_pkg::PAD_CHAR)
		else $error("character outside alphabet");

	// The stream end falls on the fourth character of a group
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_data.out_last |-> pos_q == b64e_pkg::POS_LAST)
		else $error("last mark off group boundary");

	// Pad never occupies the first two places of a group
	a_pad_pos: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && c == b64e_pkg::PAD_CHAR |-> pos_q[1])
		else $error("pad in first half of group");

endmodule

bind base64_encoder b64e_checker u_b64e_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_stall (char_stall),
	.char_data  (char_data)
);

>>> tb/sv/tb_base64_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_encoder: self-checking testbench for the base64 encoder
// Streams of bytes go in through a randomly idling driver. Every accepted byte
// runs through a local encoder that queues the characters it implies, and each
// character that leaves the block under random stall is checked against them.
// ----------------------------------------------------------------------------
module tb_base64_encoder;

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam int STREAM_BYTES = 420;

	logic           clk        = 1'b0;
	logic           arst_n     = 1'b0;
	logic           byte_valid = 1'b0;
	logic           byte_stall;
	b64e_pkg::in_t  byte_data  = '0;
	logic           char_valid;
	logic           char_stall = 1'b0;
	b64e_pkg::out_t char_data;

	// Stimulus and expected characters
	b64e_pkg::in_t  pending_q[$];
	b64e_pkg::out_t expected_chars[$];

	// Local encoder state
	logic [7:0] held_hi  = '0;
	logic [7:0] held_lo  = '0;
	logic [1:0] held_cnt = '0;

	logic byte_sent  = 1'b0;
	int   src_gap    = 0;
	int   sink_hold  = 0;
	bit   src_calm   = 1'b0;
	bit   sink_calm  = 1'b0;
	int   errors     = 0;

	base64_encoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

	always #5 clk = ~clk;

	// Six-bit value to its alphabet character
	function automatic logic [7:0] alpha_char(input logic [5:0] v);
		int idx;
		idx = 63 - int'(v);
		return ALPHABET[8*idx +: 8];
	endfunction

	function automatic void push_char(input logic [7:0] c, input logic fin);
		b64e_pkg::out_t e;
		e.out_char = c;
		e.out_last = fin;
		expected_chars.push_back(e);
	endfunction

	// Emit the characters for a 24-bit group; nchars real chars, rest padded
	function automatic void emit_group(input logic [23:0] grp, input int nchars,
			input logic fin);
		for (int i = 0; i < 4; i++) begin
			if (i < nchars) begin
				push_char(alpha_char(grp[23 - 6*i -: 6]), fin && i == 3);
			end else begin
				push_char(b64e_pkg::PAD_CHAR, fin && i == 3);
			end
		end
	endfunction

	// Encoder: hold bytes until a group closes or the stream ends
	function automatic void encode_byte(input b64e_pkg::in_t item);
		case (held_cnt)
			b64e_pkg::CNT_ONE: begin
				if (!item.last_byte) begin
					held_lo  = item.in_byte;
					held_cnt = b64e_pkg::CNT_TWO;
				end else begin
					emit_group({held_hi, item.in_byte, 8'h00}, 3, 1'b1);
					held_cnt = '0;
				end
			end
			b64e_pkg::CNT_TWO: begin
				emit_group({held_hi, held_lo, item.in_byte}, 4, item.last_byte);
				held_cnt = '0;
			end
			default: begin
				if (!item.last_byte) begin
					held_hi  = item.in_byte;
					held_cnt = b64e_pkg::CNT_ONE;
				end else begin
					emit_group({item.in_byte, 16'h0000}, 2, 1'b1);
					held_cnt = '0;
				end
			end
		endcase
	endfunction

	// Idle length: mostly none, some short, a few long
	function automatic int pick_len(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic add_byte(input logic [7:0] b, input logic fin);
		b64e_pkg::in_t item;
		item.in_byte   = b;
		item.last_byte = fin;
		pending_q.push_back(item);
	endtask

	// Check outgoing characters first, then predict from the incoming byte
	always @(posedge clk) begin
		b64e_pkg::out_t exp_c;
		byte_sent <= byte_valid && !byte_stall;
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected char %h last %b", $time,
						char_data.out_char, char_data.out_last);
					errors++;
				end else begin
					exp_c = expected_chars.pop_front();
					if (char_data.out_char !== exp_c.out_char) begin
						$display("%0t: out_char expected %h actual %h", $time,
							exp_c.out_char, char_data.out_char);
						errors++;
					end
					if (char_data.out_last !== exp_c.out_last) begin
						$display("%0t: out_last expected %b actual %b", $time,
							exp_c.out_last, char_data.out_last);
						errors++;
					end
				end
			end
			if (byte_valid && !byte_stall)
				encode_byte(byte_data);
		end
	end

	// Byte driver: next transaction once the current one is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 63) == 0)
				src_calm = !src_calm;
			if (!byte_valid || byte_sent) begin
				if (src_gap > 0) begin
					byte_valid <= 1'b0;
					src_gap--;
				end else if (pending_q.size() != 0) begin
					byte_data  <= pending_q.pop_front();
					byte_valid <= 1'b1;
					src_gap = pick_len(src_calm);
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Character sink: random stall runs
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0)
			sink_calm = !sink_calm;
		if (sink_hold > 0) begin
			char_stall <= 1'b1;
			sink_hold--;
		end else begin
			sink_hold = pick_len(sink_calm);
			char_stall <= (sink_hold > 0);
			if (sink_hold > 0)
				sink_hold--;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int len;
		logic [7:0] b;

		// one byte left over: two chars and two pads
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		// two bytes left over: three chars and one pad
		add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b1);
		// full groups closed by the last byte
		add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b1);
		add_byte(8'h4D, 1'b0); add_byte(8'h61, 1'b0); add_byte(8'h6E, 1'b1);
		// full group not last, then a one-byte tail
		add_byte(8'hFB, 1'b0); add_byte(8'hEF, 1'b0); add_byte(8'hBE, 1'b0);
		add_byte(8'h3E, 1'b1);
		// full group then a two-byte tail
		add_byte(8'h12, 1'b0); add_byte(8'h34, 1'b0); add_byte(8'h56, 1'b0);
		add_byte(8'hA5, 1'b0); add_byte(8'h5A, 1'b1);

		// Random streams, mostly short
		while (pending_q.size() < STREAM_BYTES) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(10, 30);
			else
				len = $urandom_range(1, 7);
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(0, 9))
					0:       b = 8'h00;
					1:       b = 8'hFF;
					default: b = 8'($urandom);
				endcase
				add_byte(b, k == len - 1);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || byte_valid)
			@(negedge clk);
		while (expected_chars.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		if (errors == 0 && expected_chars.size() == 0) begin
			$display("PASS base64_encoder");
		end else begin
			$display("FAIL base64_encoder");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("FAIL base64_encoder");
		$finish;
	end

endmodule
